FILE: rtl/core/sbwpf_pkg.sv
// ----------------------------------------------------------------------------
// sbwpf_pkg
// shared types and constants for the servo bus write packet framer
// ----------------------------------------------------------------------------
package sbwpf_pkg;

   // command item
   typedef struct packed {
      logic        req_type;
      logic [7:0]  servo_id;
      logic [15:0] goal_position;
      logic [15:0] move_time;
      logic [15:0] move_speed;
      logic        torque_on;
   } req_item_type;

   // result item, one packet byte
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_item_type;

   // command kinds
   localparam logic REQ_POSITION = 1'b0;
   localparam logic REQ_TORQUE   = 1'b1;

   // packet constants
   localparam logic [7:0] SYNC_BYTE     = 8'hFF;
   localparam logic [7:0] INST_WRITE    = 8'h03;
   localparam logic [7:0] ADDR_TORQUE   = 8'd40;
   localparam logic [7:0] ADDR_POSITION = 8'd42;
   localparam logic [7:0] LEN_POSITION  = 8'd9;
   localparam logic [7:0] LEN_TORQUE    = 8'd4;

   // byte positions inside a packet
   localparam int unsigned IDX_W = 4;
   localparam logic [IDX_W-1:0] IDX_SYNC0     = 4'd0;
   localparam logic [IDX_W-1:0] IDX_SYNC1     = 4'd1;
   localparam logic [IDX_W-1:0] IDX_ID        = 4'd2;
   localparam logic [IDX_W-1:0] IDX_LEN       = 4'd3;
   localparam logic [IDX_W-1:0] IDX_INST      = 4'd4;
   localparam logic [IDX_W-1:0] IDX_ADDR      = 4'd5;
   localparam logic [IDX_W-1:0] IDX_PAR0      = 4'd6;
   localparam logic [IDX_W-1:0] IDX_PAR1      = 4'd7;
   localparam logic [IDX_W-1:0] IDX_PAR2      = 4'd8;
   localparam logic [IDX_W-1:0] IDX_PAR3      = 4'd9;
   localparam logic [IDX_W-1:0] IDX_PAR4      = 4'd10;
   localparam logic [IDX_W-1:0] IDX_PAR5      = 4'd11;
   localparam logic [IDX_W-1:0] IDX_LAST_POS  = 4'd12;
   localparam logic [IDX_W-1:0] IDX_LAST_TRQ  = 4'd7;

endpackage

FILE: rtl/core/servo_bus_write_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_bus_write_packet_framer
// turns one servo write command into its byte-serial bus packet
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   req     | in        | req_valid/req_stall | sbwpf_pkg::req_item_type
//   rsp     | out       | rsp_valid/rsp_stall | sbwpf_pkg::rsp_item_type
//   csr     | in        | csr_valid/csr_ready | bus_enabled, 1 bit
//
// one packet byte leaves per cycle while rsp_stall does not hold it: a
// position write occupies the byte counter for 13 bytes, a torque write for 8,
// and a new command is taken in the same cycle the checksum byte is loaded
// reset: bus enabled, no packet in flight, output register empty
// rsp_stall holds a full output register and then freezes the byte counter
// req_stall is high while the held packet still has bytes other than the
// one leaving this cycle; a command taken while the bus is disabled is dropped
//
module servo_bus_write_packet_framer (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sbwpf_pkg::req_item_type req_data,
   // byte channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sbwpf_pkg::rsp_item_type rsp_data,
   // bus enable register
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_data
);

   // command register and packet progress
   sbwpf_pkg::req_item_type cmd_ff, cmd_in;
   logic [7:0]                 chk_ff, chk_in;
   logic [sbwpf_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       busy_ff, busy_in;
   logic                       bus_en_ff, bus_en_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   sbwpf_pkg::rsp_item_type    rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic                       advance;
   logic                       at_last;
   logic [sbwpf_pkg::IDX_W-1:0] last_idx;
   logic [7:0]                 cur_byte;
   logic [7:0]                 sum;

   // a byte moves into the output register when it is empty or draining
   assign advance   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_idx  = (cmd_ff.req_type == sbwpf_pkg::REQ_TORQUE) ?
                      sbwpf_pkg::IDX_LAST_TRQ : sbwpf_pkg::IDX_LAST_POS;
   assign at_last   = (idx_ff == last_idx);
   assign req_stall = busy_ff && !(advance && at_last);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // checksum over id, length, instruction, address and parameters
   always_comb begin
      if (req_data.req_type == sbwpf_pkg::REQ_TORQUE) begin
         sum = req_data.servo_id + sbwpf_pkg::LEN_TORQUE + sbwpf_pkg::INST_WRITE
             + sbwpf_pkg::ADDR_TORQUE + {7'd0, req_data.torque_on};
      end else begin
         sum = req_data.servo_id + sbwpf_pkg::LEN_POSITION + sbwpf_pkg::INST_WRITE
             + sbwpf_pkg::ADDR_POSITION
             + req_data.goal_position[15:8] + req_data.goal_position[7:0]
             + req_data.move_time[15:8] + req_data.move_time[7:0]
             + req_data.move_speed[15:8] + req_data.move_speed[7:0];
      end
   end

   // byte select for the current packet position
   always_comb begin
      case (idx_ff)
         sbwpf_pkg::IDX_SYNC0: cur_byte = sbwpf_pkg::SYNC_BYTE;
         sbwpf_pkg::IDX_SYNC1: cur_byte = sbwpf_pkg::SYNC_BYTE;
         sbwpf_pkg::IDX_ID:    cur_byte = cmd_ff.servo_id;
         sbwpf_pkg::IDX_LEN:   cur_byte = (cmd_ff.req_type == sbwpf_pkg::REQ_TORQUE) ?
                                          sbwpf_pkg::LEN_TORQUE : sbwpf_pkg::LEN_POSITION;
         sbwpf_pkg::IDX_INST:  cur_byte = sbwpf_pkg::INST_WRITE;
         sbwpf_pkg::IDX_ADDR:  cur_byte = (cmd_ff.req_type == sbwpf_pkg::REQ_TORQUE) ?
                                          sbwpf_pkg::ADDR_TORQUE : sbwpf_pkg::ADDR_POSITION;
         sbwpf_pkg::IDX_PAR0:  cur_byte = (cmd_ff.req_type == sbwpf_pkg::REQ_TORQUE) ?
                                          {7'd0, cmd_ff.torque_on} :
                                          cmd_ff.goal_position[15:8];
         // torque packets end here with the checksum
         sbwpf_pkg::IDX_PAR1:  cur_byte = (cmd_ff.req_type == sbwpf_pkg::REQ_TORQUE) ?
                                          chk_ff : cmd_ff.goal_position[7:0];
         sbwpf_pkg::IDX_PAR2:  cur_byte = cmd_ff.move_time[15:8];
         sbwpf_pkg::IDX_PAR3:  cur_byte = cmd_ff.move_time[7:0];
         sbwpf_pkg::IDX_PAR4:  cur_byte = cmd_ff.move_speed[15:8];
         sbwpf_pkg::IDX_PAR5:  cur_byte = cmd_ff.move_speed[7:0];
         sbwpf_pkg::IDX_LAST_POS: cur_byte = chk_ff;
         default:              cur_byte = chk_ff;
      endcase
   end

   // next state
   always_comb begin
      cmd_in       = cmd_ff;
      chk_in       = chk_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      bus_en_in    = bus_en_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         bus_en_in = csr_data;
      end

      // output register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // next byte of the held packet
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.tx_byte   = cur_byte;
         rsp_data_in.last_byte = at_last;
         idx_in                = idx_ff + 1'b1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end

      // new command; dropped while the bus is off
      if (req_fire && bus_en_ff) begin
         cmd_in  = req_data;
         chk_in  = ~sum;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         bus_en_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         bus_en_ff    <= bus_en_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chk_ff      <= chk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a command taken while the bus is on starts a packet from its first byte
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && bus_en_ff |=> busy_ff && idx_ff == '0)
      else $error("accepted command did not start a packet");

   // the byte counter never runs past the checksum position
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= last_idx)
      else $error("byte counter beyond end of packet");

   // a packet is not cut short before its checksum byte
   a_no_cut: assert property (@(posedge clock) disable iff (reset)
      advance && !at_last |=> busy_ff)
      else $error("packet ended before its checksum");

   // a command taken while the bus is off leaves nothing in flight
   a_drop: assert property (@(posedge clock) disable iff (reset)
      req_fire && !bus_en_ff |=> !busy_ff)
      else $error("dropped command started a packet");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the servo bus write packet framer: a packet
// predictor computes the byte run of every accepted command, and each byte
// that leaves is checked against it in order, while the sender runs in
// random bursts, the receiver stalls on its own pattern and the bus enable
// is set at random between phases
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int unsigned LONG_HOLD      = 80;    // one long receiver hold-off
   localparam int unsigned DRAIN_SLACK    = 4;     // settling time after the last predicted byte
   localparam int unsigned TAIL_CYCLES    = 20;    // quiet time before the verdict
   localparam int unsigned RANDOM_ITEMS   = 125;   // least number of random commands over all phases

   // receiver stall behavior, picked at random whenever the current mode runs out
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // --------------------------------------------------------------------------
   // packet predictor and byte checker
   // --------------------------------------------------------------------------
   class packet_scoreboard;
      sbwpf_pkg::rsp_item_type pending_bytes[$];
      bit           bus_on;
      int unsigned  errors;

      function new();
         bus_on = 1'b1;
         errors = 0;
      endfunction

      function void set_bus_enable(logic value);
         bus_on = value;
      endfunction

      // builds the full write packet of one command, none while the bus is off
      function void note_command(sbwpf_pkg::req_item_type cmd);
         logic [7:0]   params[$];
         logic [7:0]   frame[$];
         logic [7:0]   reg_addr;
         logic [7:0]   len;
         logic [7:0]   sum;
         sbwpf_pkg::rsp_item_type next_byte;
         if (!bus_on) return;
         if (cmd.req_type == sbwpf_pkg::REQ_POSITION) begin
            params.push_back(cmd.goal_position[15:8]);
            params.push_back(cmd.goal_position[7:0]);
            params.push_back(cmd.move_time[15:8]);
            params.push_back(cmd.move_time[7:0]);
            params.push_back(cmd.move_speed[15:8]);
            params.push_back(cmd.move_speed[7:0]);
            reg_addr = sbwpf_pkg::ADDR_POSITION;
         end else begin
            params.push_back({7'd0, cmd.torque_on});
            reg_addr = sbwpf_pkg::ADDR_TORQUE;
         end
         len = 8'(params.size() + 3);
         sum = cmd.servo_id + len + sbwpf_pkg::INST_WRITE + reg_addr;
         frame.push_back(sbwpf_pkg::SYNC_BYTE);
         frame.push_back(sbwpf_pkg::SYNC_BYTE);
         frame.push_back(cmd.servo_id);
         frame.push_back(len);
         frame.push_back(sbwpf_pkg::INST_WRITE);
         frame.push_back(reg_addr);
         foreach (params[i]) begin
            frame.push_back(params[i]);
            sum = sum + params[i];
         end
         frame.push_back(~sum);
         foreach (frame[i]) begin
            next_byte.tx_byte   = frame[i];
            next_byte.last_byte = (i == frame.size() - 1);
            pending_bytes.push_back(next_byte);
         end
      endfunction

      function void check_byte(sbwpf_pkg::rsp_item_type got);
         sbwpf_pkg::rsp_item_type want;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte: expected none, got tx_byte %h last_byte %b",
                     $time, got.tx_byte, got.last_byte);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.tx_byte !== want.tx_byte) begin
            errors++;
            $display("%0t: tx_byte mismatch: expected %h, got %h",
                     $time, want.tx_byte, got.tx_byte);
         end
         if (got.last_byte !== want.last_byte) begin
            errors++;
            $display("%0t: last_byte mismatch: expected %b, got %b",
                     $time, want.last_byte, got.last_byte);
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and block hookup
   // --------------------------------------------------------------------------
   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sbwpf_pkg::req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   sbwpf_pkg::rsp_item_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;

   packet_scoreboard sb;

   // receiver state
   stall_mode_type stall_mode;
   int unsigned  mode_left;
   int unsigned  hold_left;
   logic         hold_armed;
   logic         hold_done;

   int unsigned  idle_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   servo_bus_write_packet_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // --------------------------------------------------------------------------
   // monitor: every handshake is seen at the edge that completes it
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // bytes in flight belong to older commands, so check before noting
         if (rsp_valid && !rsp_stall) sb.check_byte(rsp_data);
         if (req_valid && !req_stall) sb.note_command(req_data);
         if (csr_valid && csr_ready) sb.set_bus_enable(csr_data);
      end
   end

   // --------------------------------------------------------------------------
   // watchdog: too long with no handshake of any kind ends the run
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // receiver: stall pattern of its own, plus one long hold-off once armed
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         // long hold so the framer backs up and stalls the command side
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD - 1;
         hold_done <= 1'b1;
      end else if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(16, 64);
         rsp_stall  <= 1'b0;
      end else begin
         mode_left <= mode_left - 1;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (mode_left[1:0] == 2'd0);
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // driving tasks
   // --------------------------------------------------------------------------

   // offers one command after an optional gap and holds it until taken
   task automatic send_command(sbwpf_pkg::req_item_type cmd, int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= cmd;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // waits until every predicted byte is out and the framer has settled
   task automatic wait_drained();
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // bus enable is only changed with the framer idle
   task automatic write_bus_enable(logic value);
      req_valid <= 1'b0;
      wait_drained();
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic sbwpf_pkg::req_item_type make_command(logic kind, logic [7:0] id,
                                                            logic [15:0] pos,
                                                            logic [15:0] tim,
                                                            logic [15:0] spd, logic tq);
      sbwpf_pkg::req_item_type cmd;
      cmd.req_type      = kind;
      cmd.servo_id      = id;
      cmd.goal_position = pos;
      cmd.move_time     = tim;
      cmd.move_speed    = spd;
      cmd.torque_on     = tq;
      return cmd;
   endfunction

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      sbwpf_pkg::req_item_type cmd;
      int unsigned  sent_items;
      int unsigned  count;
      int unsigned  burst_left;
      int unsigned  gap;
      logic         enable;
      bit           first_phase;

      sb          = new();
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      stall_mode  = STALL_NONE;
      mode_left   = 0;
      hold_left   = 0;
      hold_armed  = 1'b0;
      hold_done   = 1'b0;
      idle_cycles = 0;
      sent_items  = 0;
      burst_left  = 0;
      first_phase = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, both command kinds, ignored fields set,
      // checksum landing on 0x00 and on 0xff
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd0, 16'h0000, 16'h0000,
                                16'h0000, 1'b0), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd255, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 1'b1), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'hAA, 16'h5555, 16'hAAAA,
                                16'h00FF, 1'b0), 3);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'h55, 16'hAAAA, 16'h5555,
                                16'hFF00, 1'b1), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd1, 16'h8001, 16'h0180,
                                16'h7FFE, 1'b0), 0);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd0, 16'h0000, 16'h0000,
                                16'h0000, 1'b0), 0);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd255, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 1'b1), 2);
      // torque sum 0xff gives checksum 0x00, sum wrapping to 0 gives 0xff
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd208, 16'h0000, 16'h0000,
                                16'h0000, 1'b0), 0);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd209, 16'h0000, 16'h0000,
                                16'h0000, 1'b0), 0);
      // same two checksum corners for a position write
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd201, 16'h0000, 16'h0000,
                                16'h0000, 1'b0), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd202, 16'h0000, 16'h0000,
                                16'h0000, 1'b1), 1);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd1, 16'h1234, 16'h5678,
                                16'h9ABC, 1'b1), 0);

      // bus disabled: both kinds are dropped, back to back and with a gap
      write_bus_enable(1'b0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd3, 16'hFFFF, 16'h0000,
                                16'hFFFF, 1'b1), 0);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd4, 16'h0000, 16'hFFFF,
                                16'h0000, 1'b1), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd5, 16'h1111, 16'h2222,
                                16'h3333, 1'b0), 2);
      write_bus_enable(1'b1);
      send_command(make_command(sbwpf_pkg::REQ_TORQUE, 8'd7, 16'h0000, 16'h0000,
                                16'h0000, 1'b1), 0);
      send_command(make_command(sbwpf_pkg::REQ_POSITION, 8'd8, 16'hABCD, 16'hEF01,
                                16'h2345, 1'b0), 0);

      // random phases; the first one keeps the bus on and carries the long hold
      while (sent_items < RANDOM_ITEMS) begin
         enable = first_phase ? 1'b1 : ($urandom_range(0, 3) != 0);
         count  = first_phase ? 40 : $urandom_range(10, 30);
         write_bus_enable(enable);
         if (first_phase) hold_armed <= 1'b1;
         for (int unsigned n = 0; n < count; n++) begin
            cmd.req_type      = 1'($urandom_range(0, 1));
            cmd.servo_id      = 8'($urandom_range(0, 255));
            cmd.goal_position = 16'($urandom_range(0, 65535));
            cmd.move_time     = 16'($urandom_range(0, 65535));
            cmd.move_speed    = 16'($urandom_range(0, 65535));
            cmd.torque_on     = 1'($urandom_range(0, 1));
            // bursts of random length, random gaps, some bursts run on with no gap
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 15);
               gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               gap = 0;
            end
            burst_left--;
            send_command(cmd, gap);
            sent_items++;
         end
         first_phase = 1'b0;
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/sbwpf_pkg.sv
rtl/core/servo_bus_write_packet_framer.sv
sim/tb_top.sv
